// ===== sv/fprt_pkg.sv =====
// ----------------------------------------------------------------------------
// fprt_pkg
// Shared types and codes for the flash partition range table.
// ----------------------------------------------------------------------------
package fprt_pkg;

   // Transaction kinds
   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_MISS      = 3'd1;
   localparam logic [2:0] STS_FULL      = 3'd2;
   localparam logic [2:0] STS_BAD_RANGE = 3'd3;
   localparam logic [2:0] STS_OVERFLOW  = 3'd4;

   localparam int unsigned BASE_W   = 20;
   localparam int unsigned SIZE_W   = 21;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned USED_W   = 21;

   localparam logic [BASE_W-1:0] HEADER_RESET = 20'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_DIFF,
      S_ADD_ROUND,
      S_ADD_PLACE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [BASE_W-1:0]   base_block;
      logic [SIZE_W-1:0]   size_blocks;
      logic [ADDR_W-1:0]   actual_bytes;
      logic [ID_W-1:0]     id_out;
   } result_type;

endpackage

// ===== sv/fprt_ifs.sv =====
// ----------------------------------------------------------------------------
// fprt_req_if / fprt_rsp_if
// Valid/ready channels for table transactions and their results.
// ----------------------------------------------------------------------------
interface fprt_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] start_addr;
   logic [31:0] end_addr;
   logic [31:0] part_id;
   logic [31:0] offset;

   modport source (output valid, kind, start_addr, end_addr, part_id, offset,
                   input ready);
   modport sink   (input valid, kind, start_addr, end_addr, part_id, offset,
                   output ready);
endinterface

interface fprt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  slot;
   logic [19:0] base_block;
   logic [20:0] size_blocks;
   logic [31:0] actual_bytes;
   logic [31:0] id_out;

   modport source (output valid, status, slot, base_block, size_blocks,
                   actual_bytes, id_out, input ready);
   modport sink   (input valid, status, slot, base_block, size_blocks,
                   actual_bytes, id_out, output ready);
endinterface

// ===== sv/fprt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// fprt_entry_ram
// Partition entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fprt_entry_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  fprt_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output fprt_pkg::entry_type rd_data
);

   fprt_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/fprt_range_cmp.sv =====
// ----------------------------------------------------------------------------
// fprt_range_cmp
// Block range compare: is point inside [base, base + size)?
// ----------------------------------------------------------------------------
module fprt_range_cmp #(
   parameter int W = 24
) (
   input  logic [W-1:0] point,
   input  logic [W-1:0] base,
   input  logic [W-1:0] size,
   output logic         hit
);

   logic [W-1:0] range_end;

   assign range_end = base + size;
   assign hit       = (point >= base) && (point < range_end);

endmodule

// ===== sv/flash_partition_range_table.sv =====
// ----------------------------------------------------------------------------
// flash_partition_range_table
// Partition allocator and offset lookup over erase-block ranges.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; req.ready is high only while the
// sequencer is idle, and a finished result waits in the output register
// without holding off the next request. An add puts its result in the output
// register after its difference, round-up, place and hand-off steps, or goes
// from the difference step straight to hand-off when the table is full or the
// range is reversed. A lookup reads the entry memory one slot per cycle
// through a single compare unit: a miss reads every stored entry before its
// result is handed off, and a hit on a slot ends the scan there. The next
// transaction is taken only after the result is loaded into the output
// register, and the load waits while that register holds an unaccepted
// result. csr_wr_data sets the header block count used as the start of
// allocation for later adds.
// ----------------------------------------------------------------------------
module flash_partition_range_table #(
   parameter int MAX_PARTS   = 32,
   parameter int BLOCK_SHIFT = 12
) (
   input  logic                clock,
   input  logic                reset,
   fprt_req_if.sink            req_chan,
   fprt_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [19:0]         csr_wr_data
);

   localparam int CW         = $clog2(MAX_PARTS + 1);
   localparam int AW         = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int BLK_W      = 32 - BLOCK_SHIFT;
   localparam int NB_W       = BLK_W + 1;
   localparam int RW         = ((NB_W > 22) ? NB_W : 22) + 1;
   localparam int LIMIT_BITS = (BLK_W < 20) ? BLK_W : 20;
   localparam logic [RW-1:0]  LIMIT   = RW'(1) << LIMIT_BITS;
   localparam logic [CW-1:0]  MAX_CNT = CW'(MAX_PARTS);

   fprt_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [20:0]          used_ff, used_in;
   logic [19:0]          header_ff;
   logic [CW-1:0]        issue_idx_ff, issue_idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [AW-1:0]        pend_idx_ff, pend_idx_in;

   logic [31:0]          start_ff, end_ff, id_ff, offset_ff;
   logic [31:0]          bytes_ff, bytes_in;
   logic [21:0]          base_ff, base_in;
   logic [NB_W-1:0]      blocks_ff, blocks_in;
   fprt_pkg::result_type res_ff, res_in;
   fprt_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_take;
   logic                 rsp_load;
   logic [32:0]          diff;
   logic [RW-1:0]        place_end;
   logic                 place_bad;

   logic                 ram_we;
   logic [AW-1:0]        ram_raddr;
   fprt_pkg::entry_type  ram_wdata, ram_rdata;
   logic [RW-1:0]        cmp_point;
   logic                 cmp_hit;

   fprt_entry_ram #(.DEPTH(MAX_PARTS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cmp_point = RW'(offset_ff >> BLOCK_SHIFT);

   fprt_range_cmp #(.W(RW)) u_cmp (
      .point (cmp_point),
      .base  (RW'(ram_rdata.base)),
      .size  (RW'(ram_rdata.size)),
      .hit   (cmp_hit)
   );

   assign req_chan.ready = (state_ff == fprt_pkg::S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign diff      = {1'b0, end_ff} - {1'b0, start_ff};
   assign place_end = RW'(base_ff) + RW'(blocks_ff);
   assign place_bad = (RW'(base_ff) >= LIMIT) || (place_end > LIMIT);

   assign ram_raddr = issue_idx_ff[AW-1:0];
   assign ram_wdata = '{base: base_ff[19:0], size: 21'(blocks_ff), id: id_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      issue_idx_in  = issue_idx_ff;
      pend_valid_in = 1'b0;
      pend_idx_in   = pend_idx_ff;
      bytes_in      = bytes_ff;
      base_in       = base_ff;
      blocks_in     = blocks_ff;
      res_in        = res_ff;
      ram_we        = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         fprt_pkg::S_IDLE: begin
            issue_idx_in = '0;
            if (req_take) begin
               state_in = (req_chan.kind == fprt_pkg::KIND_ADD) ?
                          fprt_pkg::S_ADD_DIFF : fprt_pkg::S_SCAN;
            end
         end
         fprt_pkg::S_ADD_DIFF: begin
            bytes_in = diff[31:0];
            base_in  = 22'(header_ff) + 22'(used_ff);
            res_in   = '0;
            priority if (count_ff >= MAX_CNT) begin
               res_in.status = fprt_pkg::STS_FULL;
               state_in      = fprt_pkg::S_DONE;
            end else if (diff[32]) begin
               res_in.status = fprt_pkg::STS_BAD_RANGE;
               state_in      = fprt_pkg::S_DONE;
            end else begin
               state_in = fprt_pkg::S_ADD_ROUND;
            end
         end
         fprt_pkg::S_ADD_ROUND: begin
            // round up to whole erase blocks
            blocks_in = NB_W'(bytes_ff >> BLOCK_SHIFT)
                      + NB_W'(|bytes_ff[BLOCK_SHIFT-1:0]);
            state_in  = fprt_pkg::S_ADD_PLACE;
         end
         fprt_pkg::S_ADD_PLACE: begin
            res_in = '0;
            if (place_bad) begin
               res_in.status = fprt_pkg::STS_OVERFLOW;
            end else begin
               ram_we             = 1'b1;
               count_in           = count_ff + CW'(1);
               used_in            = 21'(used_ff + 21'(blocks_ff));
               res_in.status      = fprt_pkg::STS_OK;
               res_in.slot        = 5'(count_ff);
               res_in.base_block  = base_ff[19:0];
               res_in.size_blocks = 21'(blocks_ff);
               res_in.actual_bytes = bytes_ff;
               res_in.id_out      = id_ff;
            end
            state_in = fprt_pkg::S_DONE;
         end
         fprt_pkg::S_SCAN: begin
            // issue the next slot read while checking the one already read
            if (issue_idx_ff < count_ff) begin
               pend_valid_in = 1'b1;
               pend_idx_in   = issue_idx_ff[AW-1:0];
               issue_idx_in  = issue_idx_ff + CW'(1);
            end
            res_in = '0;
            priority if (pend_valid_ff && cmp_hit) begin
               pend_valid_in      = 1'b0;
               res_in.status      = fprt_pkg::STS_OK;
               res_in.slot        = 5'(pend_idx_ff);
               res_in.base_block  = ram_rdata.base;
               res_in.size_blocks = ram_rdata.size;
               res_in.id_out      = ram_rdata.id;
               state_in           = fprt_pkg::S_DONE;
            end else if (!pend_valid_ff && (issue_idx_ff >= count_ff)) begin
               res_in.status = fprt_pkg::STS_MISS;
               state_in      = fprt_pkg::S_DONE;
            end else begin
               state_in = fprt_pkg::S_SCAN;
            end
         end
         fprt_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = fprt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fprt_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fprt_pkg::S_IDLE;
         count_ff      <= '0;
         used_ff       <= '0;
         header_ff     <= fprt_pkg::HEADER_RESET;
         issue_idx_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         issue_idx_ff  <= issue_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff  <= req_chan.start_addr;
         end_ff    <= req_chan.end_addr;
         id_ff     <= req_chan.part_id;
         offset_ff <= req_chan.offset;
      end
      pend_idx_ff <= pend_idx_in;
      bytes_ff    <= bytes_in;
      base_ff     <= base_in;
      blocks_ff   <= blocks_in;
      res_ff      <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.slot         = rsp_ff.slot;
   assign rsp_chan.base_block   = rsp_ff.base_block;
   assign rsp_chan.size_blocks  = rsp_ff.size_blocks;
   assign rsp_chan.actual_bytes = rsp_ff.actual_bytes;
   assign rsp_chan.id_out       = rsp_ff.id_out;

endmodule
